// File: hw/rtl/sts_pkg.sv
// Shared types and constants of the series trend statistics block.
package sts_pkg;

    localparam int unsigned SAMPLE_W     = 32;
    localparam int unsigned PERIOD_REG_W = 9;
    localparam int unsigned KIND_W       = 4;
    localparam int unsigned CFG_ADDR_W   = 1;

    localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 32'sh8000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_T1_PERIOD = 1'b0,
        CFG_T2_PERIOD = 1'b1
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_EQ_1    = 4'd0,
        KIND_EQ_T1   = 4'd1,
        KIND_EQ_T2   = 4'd2,
        KIND_INC_1   = 4'd3,
        KIND_INC_T1  = 4'd4,
        KIND_INC_T2  = 4'd5,
        KIND_DEC_1   = 4'd6,
        KIND_DEC_T1  = 4'd7,
        KIND_DEC_T2  = 4'd8,
        KIND_MIN     = 4'd9,
        KIND_MAX     = 4'd10,
        KIND_MEAN    = 4'd11,
        KIND_LEAGUE  = 4'd12
    } t_kind;

    // one classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       first;    // first sample of the run
        logic                       take_t1;  // taken at stride T1
        logic                       take_t2;  // taken at stride T2
        logic                       drop;     // run already full
    } t_item;

endpackage

// File: hw/rtl/sts_front.sv
// Front end: accepts samples, tracks run length and stride phases, tags each item.
module sts_front #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_PERIOD  = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [sts_pkg::PERIOD_REG_W-1:0]       i_t1_period,
    input  logic [sts_pkg::PERIOD_REG_W-1:0]       i_t2_period,
    input  logic                                   i_valid,
    input  logic signed [sts_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_last,
    input  logic                                   i_full,
    output logic                                   o_ready,
    output logic                                   o_push,
    output sts_pkg::t_item                         o_item
);
    import sts_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned EPW  = $clog2(MAX_PERIOD + 1);
    localparam int unsigned CMPW = (EPW > PERIOD_REG_W) ? EPW : PERIOD_REG_W;
    localparam int unsigned PHW  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

    logic [CW-1:0]   r_count;
    logic [PHW-1:0]  r_ph1, r_ph2;
    logic [CMPW-1:0] w_per1, w_per2, w_nx1, w_nx2;
    logic [PHW-1:0]  n_ph1, n_ph2;
    logic            w_drop;

    // zero acts as stride 1, oversize clamps to MAX_PERIOD
    assign w_per1 = (i_t1_period == '0) ? CMPW'(1) :
                    (CMPW'(i_t1_period) > CMPW'(MAX_PERIOD)) ? CMPW'(MAX_PERIOD) :
                    CMPW'(i_t1_period);
    assign w_per2 = (i_t2_period == '0) ? CMPW'(1) :
                    (CMPW'(i_t2_period) > CMPW'(MAX_PERIOD)) ? CMPW'(MAX_PERIOD) :
                    CMPW'(i_t2_period);

    assign w_nx1 = CMPW'(r_ph1) + CMPW'(1);
    assign w_nx2 = CMPW'(r_ph2) + CMPW'(1);
    assign n_ph1 = (w_nx1 >= w_per1) ? '0 : w_nx1[PHW-1:0];
    assign n_ph2 = (w_nx2 >= w_per2) ? '0 : w_nx2[PHW-1:0];

    assign w_drop  = (r_count == CW'(MAX_SAMPLES));
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign o_item.sample  = i_sample;
    assign o_item.last    = i_last;
    assign o_item.first   = (r_count == '0);
    assign o_item.take_t1 = (r_ph1 == '0);
    assign o_item.take_t2 = (r_ph2 == '0);
    assign o_item.drop    = w_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ph1   <= '0;
            r_ph2   <= '0;
        end else if (o_push) begin
            if (i_last) begin
                r_count <= '0;
                r_ph1   <= '0;
                r_ph2   <= '0;
            end else if (!w_drop) begin
                r_count <= r_count + CW'(1);
                r_ph1   <= n_ph1;
                r_ph2   <= n_ph2;
            end
        end
    end

endmodule

// File: hw/rtl/sts_queue.sv
// Small item queue between front and back.
module sts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sts_pkg::t_item i_item,
    input  logic           i_pop,
    output sts_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);
    import sts_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned AW    = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (AW+1)'(DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (AW+1)'(1);
            end
        end
    end

endmodule

// File: hw/rtl/sts_back.sv
// Back end: trend counting, min/max/sum, mean division and result emission.
module sts_back #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  sts_pkg::t_item                         i_item,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [sts_pkg::KIND_W-1:0]             o_kind,
    output logic signed [sts_pkg::SAMPLE_W-1:0]    o_value,
    output logic                                   o_last
);
    import sts_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned KW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int unsigned STW   = $clog2(SUM_W);

    typedef enum logic [1:0] {
        S_ACCUM,
        S_LOAD,
        S_DIVIDE,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic signed [SAMPLE_W-1:0] r_prior, r_held1, r_held2;
    logic signed [SAMPLE_W-1:0] r_min, r_max;
    logic signed [SUM_W-1:0]    r_sum;
    logic [KW-1:0]              r_tc [9];
    logic [SUM_W-1:0]           r_quo;
    logic [CW:0]                r_rem;
    logic                       r_neg;
    logic [STW-1:0]             r_step;
    t_kind                      r_kind;

    logic signed [SAMPLE_W-1:0] w_s;
    logic signed [SAMPLE_W-1:0] w_ref [3];
    logic [2:0]                 w_en;
    logic [CW:0]                w_rem_sh;
    logic                       w_ge;
    logic [SAMPLE_W-1:0]        w_mean, w_league;
    logic [SUM_W-1:0]           w_mag;

    assign o_pop = (r_state == S_ACCUM) && i_valid;
    assign w_s   = i_item.sample;

    // newer sample of each pair and whether that stride compares this item
    assign w_ref[0] = r_prior;
    assign w_ref[1] = r_held1;
    assign w_ref[2] = r_held2;
    assign w_en[0]  = !i_item.first;
    assign w_en[1]  = !i_item.first && i_item.take_t1;
    assign w_en[2]  = !i_item.first && i_item.take_t2;

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem[CW-1:0], r_quo[SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_count});
    assign w_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    assign w_mean   = r_neg ? (-r_quo[SAMPLE_W-1:0]) : r_quo[SAMPLE_W-1:0];
    assign w_league = SAMPLE_W'(r_tc[0]) + SAMPLE_W'({r_tc[3], 1'b0}) + SAMPLE_W'(r_tc[3]);

    assign o_valid = (r_state == S_EMIT);
    assign o_kind  = r_kind;
    assign o_last  = (r_kind == KIND_LEAGUE);

    always_comb begin
        case (r_kind)
            KIND_EQ_1:   o_value = SAMPLE_W'(r_tc[0]);
            KIND_EQ_T1:  o_value = SAMPLE_W'(r_tc[1]);
            KIND_EQ_T2:  o_value = SAMPLE_W'(r_tc[2]);
            KIND_INC_1:  o_value = SAMPLE_W'(r_tc[3]);
            KIND_INC_T1: o_value = SAMPLE_W'(r_tc[4]);
            KIND_INC_T2: o_value = SAMPLE_W'(r_tc[5]);
            KIND_DEC_1:  o_value = SAMPLE_W'(r_tc[6]);
            KIND_DEC_T1: o_value = SAMPLE_W'(r_tc[7]);
            KIND_DEC_T2: o_value = SAMPLE_W'(r_tc[8]);
            KIND_MIN:    o_value = r_min;
            KIND_MAX:    o_value = r_max;
            KIND_MEAN:   o_value = w_mean;
            KIND_LEAGUE: o_value = w_league;
            default:     o_value = '0;
        endcase
    end

    // held samples and the divider are payload: the first item of a run loads the held samples, S_LOAD the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_count <= '0;
            r_min   <= MIN_INIT;
            r_max   <= MAX_INIT;
            r_sum   <= '0;
            r_kind  <= KIND_EQ_1;
            r_step  <= '0;
            for (int j = 0; j < 9; j++) begin
                r_tc[j] <= '0;
            end
        end else begin
            case (r_state)
                S_ACCUM: begin
                    if (o_pop) begin
                        if (!i_item.drop) begin
                            for (int j = 0; j < 3; j++) begin
                                if (w_en[j]) begin
                                    if (w_ref[j] == w_s) begin
                                        r_tc[j] <= r_tc[j] + KW'(1);
                                    end else if (w_ref[j] > w_s) begin
                                        r_tc[3+j] <= r_tc[3+j] + KW'(1);
                                    end else begin
                                        r_tc[6+j] <= r_tc[6+j] + KW'(1);
                                    end
                                end
                            end
                            r_prior <= w_s;
                            if (i_item.take_t1) begin
                                r_held1 <= w_s;
                            end
                            if (i_item.take_t2) begin
                                r_held2 <= w_s;
                            end
                            if (w_s < r_min) begin
                                r_min <= w_s;
                            end
                            if (w_s > r_max) begin
                                r_max <= w_s;
                            end
                            r_sum   <= r_sum + SUM_W'(w_s);
                            r_count <= r_count + CW'(1);
                        end
                        if (i_item.last) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // sum and count now include the last item, unless it was dropped
                    r_quo   <= w_mag;
                    r_neg   <= r_sum[SUM_W-1];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    r_rem  <= w_ge ? (w_rem_sh - {1'b0, r_count}) : w_rem_sh;
                    r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                    r_step <= r_step + STW'(1);
                    if (r_step == STW'(SUM_W - 1)) begin
                        r_state <= S_EMIT;
                        r_kind  <= KIND_EQ_1;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        if (r_kind == KIND_LEAGUE) begin
                            r_state <= S_ACCUM;
                            r_count <= '0;
                            r_min   <= MIN_INIT;
                            r_max   <= MAX_INIT;
                            r_sum   <= '0;
                            for (int j = 0; j < 9; j++) begin
                                r_tc[j] <= '0;
                            end
                        end else begin
                            r_kind <= t_kind'(r_kind + KIND_W'(1));
                        end
                    end
                end
                default: r_state <= S_ACCUM;
            endcase
        end
    end

endmodule

// File: hw/rtl/series_trend_statistics.sv
// Top level of the series trend statistics block.
module series_trend_statistics #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_PERIOD  = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [sts_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [sts_pkg::PERIOD_REG_W-1:0]       i_cfg_wdata,
    // sample input
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [31:0]                            i_s_axis_tdata,  // [31:0] sample
    input  logic                                   i_s_axis_tlast,  // last_sample
    // statistic output
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [31:0]                            o_m_axis_tdata,  // [31:0] stat_value
    output logic [3:0]                             o_m_axis_tuser,  // [3:0] stat_kind
    output logic                                   o_m_axis_tlast   // last_stat
);
    // Samples (signed Q16.16, newest first) stream in one per cycle while the
    // queue has room. The front end tags each item with its stride phases and
    // run position and marks items past MAX_SAMPLES to be dropped; a 4-entry
    // queue hands items to the back end, which updates the trend counters, min,
    // max and sum at one item per cycle while accumulating. The item marked last
    // makes the back end latch the final sum, then divide it by the sample
    // count, one quotient bit per cycle, then emit the 13 statistics in kind
    // order, one per accepted output cycle, tlast on the league points. The
    // input keeps flowing until the queue fills during the divide and emit
    // phases.
    // Stride registers: index 0 is T1 (reset 5), index 1 is T2 (reset 20);
    // write them only while the block is idle.
    import sts_pkg::*;

    logic [PERIOD_REG_W-1:0] r_t1_period, r_t2_period;
    logic                    w_push, w_pop, w_empty, w_full;
    t_item                   w_in_item, w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_period <= PERIOD_REG_W'(5);
            r_t2_period <= PERIOD_REG_W'(20);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_T1_PERIOD: r_t1_period <= i_cfg_wdata;
                CFG_T2_PERIOD: r_t2_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sts_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_PERIOD  (MAX_PERIOD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_t1_period (r_t1_period),
        .i_t2_period (r_t2_period),
        .i_valid     (i_s_axis_tvalid),
        .i_sample    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_full      (w_full),
        .o_ready     (o_s_axis_tready),
        .o_push      (w_push),
        .o_item      (w_in_item)
    );

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sts_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (o_m_axis_tuser),
        .o_value (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // back end never consumes items while emitting statistics
    a_no_pop_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !o_m_axis_tvalid)
        else $error("item consumed during emission");

    // only the league statistic closes a run
    a_last_is_league: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tlast |-> (o_m_axis_tuser == KIND_LEAGUE))
        else $error("tlast on wrong statistic");

    // after the final statistic the back end returns to accumulating
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("emission continued past last statistic");
`endif

endmodule

// File: verif/sts_checker.sv
// Checker for the series trend statistics block: predicts the statistics and compares them.
module sts_checker #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_PERIOD  = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sts_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sts_pkg::PERIOD_REG_W-1:0] i_cfg_wdata,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [31:0]                      i_s_tdata,   // [31:0] sample
    input  logic                             i_s_tlast,   // last_sample
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [31:0]                      i_m_tdata,   // [31:0] stat_value
    input  logic [3:0]                       i_m_tuser,   // [3:0] stat_kind
    input  logic                             i_m_tlast,   // last_stat
    output int                               o_fail_count,
    output int                               o_pending
);
    import sts_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_stat_exp;

    t_stat_exp expected_stats[$];

    logic [PERIOD_REG_W-1:0] t1_reg, t2_reg;
    int unsigned             run_len;
    logic signed [31:0]      held [3];   // last taken sample per stride
    int unsigned             phase [3];
    int unsigned             trend_cnt [9];
    logic signed [31:0]      run_min, run_max;
    longint                  run_sum;
    int                      fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    function automatic int unsigned eff_stride(logic [PERIOD_REG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_PERIOD) return MAX_PERIOD;
        return r;
    endfunction

    function automatic int unsigned stride_of(int slot);
        if (slot == 1) return eff_stride(t1_reg);
        if (slot == 2) return eff_stride(t2_reg);
        return 1;
    endfunction

    function void clear_run();
        run_len = 0;
        for (int k = 0; k < 3; k++) begin
            held[k]  = '0;
            phase[k] = 0;
        end
        for (int k = 0; k < 9; k++) trend_cnt[k] = 0;
        run_min = MIN_INIT;
        run_max = MAX_INIT;
        run_sum = 0;
    endfunction

    // slot 0 is the plain neighbor compare, 1 and 2 the strided ones
    function void fold_sample(logic signed [31:0] s, logic last);
        t_stat_exp   e;
        longint      v;
        int unsigned nxt;
        if (run_len < MAX_SAMPLES) begin
            for (int slot = 0; slot < 3; slot++) begin
                if (phase[slot] == 0) begin
                    if (run_len > 0) begin
                        if (held[slot] == s) trend_cnt[slot]++;
                        else if (held[slot] > s) trend_cnt[3 + slot]++;
                        else trend_cnt[6 + slot]++;
                    end
                    held[slot] = s;
                end
                nxt = phase[slot] + 1;
                phase[slot] = (nxt >= stride_of(slot)) ? 0 : nxt;
            end
            if (s < run_min) run_min = s;
            if (s > run_max) run_max = s;
            run_sum += longint'(s);
            run_len++;
        end
        if (last) begin
            for (int k = 0; k < 13; k++) begin
                case (k)
                    9:       v = longint'(run_min);
                    10:      v = longint'(run_max);
                    11:      v = run_sum / longint'(run_len);  // truncates toward zero
                    12:      v = longint'(trend_cnt[0]) + 3 * longint'(trend_cnt[3]);
                    default: v = longint'(trend_cnt[k]);
                endcase
                e.kind  = t_kind'(k[KIND_W-1:0]);
                e.value = v[31:0];
                e.last  = (e.kind == KIND_LEAGUE);
                expected_stats.push_back(e);
            end
            clear_run();
        end
    endfunction

    function void note_failure(string why, t_stat_exp e);
        fail_total++;
        if (fail_total <= 10)
            $display({"stat mismatch (%s): kind exp %0d got %0d, ",
                      "value exp %h got %h, last exp %0b got %0b"},
                     why, e.kind, i_m_tuser, e.value, i_m_tdata, e.last, i_m_tlast);
    endfunction

    function void check_stat();
        t_stat_exp e;
        if (expected_stats.size() == 0) begin
            e.kind  = KIND_EQ_1;
            e.value = '0;
            e.last  = 1'b0;
            note_failure("nothing expected", e);
        end else begin
            e = expected_stats.pop_front();
            if (i_m_tuser != e.kind || i_m_tdata != e.value || i_m_tlast != e.last)
                note_failure("field", e);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            t1_reg = 9'd5;
            t2_reg = 9'd20;
            clear_run();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_T1_PERIOD: t1_reg = i_cfg_wdata;
                    CFG_T2_PERIOD: t2_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) fold_sample($signed(i_s_tdata), i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_stat();
        end
        o_pending    <= expected_stats.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/tb_series_trend_statistics.sv
// Testbench top for series_trend_statistics: stimulus, back-pressure and verdict.
module tb_series_trend_statistics;
    import sts_pkg::*;

    localparam int unsigned MAX_SAMPLES = 4096;
    localparam int unsigned MAX_PERIOD  = 256;
    // the mean division is the slow step; give the block ample time to go idle
    localparam int          SETTLE      = 100;
    localparam int          CYCLE_LIMIT = 400000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [PERIOD_REG_W-1:0] cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [31:0]             s_tdata = '0;   // [31:0] sample
    logic                    s_tlast = 1'b0; // last_sample
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [31:0]             m_tdata;        // [31:0] stat_value
    logic [3:0]              m_tuser;        // [3:0] stat_kind
    logic                    m_tlast;        // last_stat

    int fail_count;
    int pending;
    int send_idle = 7;    // percent of cycles the sender holds back
    int recv_idle = 84;   // percent of cycles the receiver stalls
    int cycles = 0;

    series_trend_statistics #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_PERIOD (MAX_PERIOD)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    sts_checker #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_PERIOD (MAX_PERIOD)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 12-unit period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge i_clk) m_tready = ($urandom_range(99) >= recv_idle);

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One item on the sample stream; returns at the accepting rising edge.
    task automatic push_sample(input logic [31:0] value, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tlast  = last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stop sending, wait for every predicted statistic, then let the block settle.
    task automatic drain_stats();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Only called with the block idle (after drain_stats or right after reset).
    task automatic write_period(input t_cfg_idx idx, input logic [PERIOD_REG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // strides: mostly small, with zero, one, top of range and beyond it mixed in
    function automatic logic [PERIOD_REG_W-1:0] pick_period();
        case ($urandom_range(6))
            0:       return '0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'h1FF;
            default: return 9'($urandom_range(2, 12));
        endcase
    endfunction

    // Well-formed series with random content: plenty of equal, near and wide steps.
    function automatic logic [31:0] next_sample(input logic [31:0] prev);
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(6)) - 3);
            2:       return prev;
            default: return prev + 32'(int'($urandom_range(4)) - 2);
        endcase
    endfunction

    // Whole runs under random strides until about `quota` samples have gone in.
    task automatic random_phase(input int quota);
        int          sent;
        int          runs;
        int          len;
        logic [31:0] v;
        sent = 0;
        runs = 0;
        v    = '0;
        while (sent < quota) begin
            if (runs % 4 == 0) begin
                drain_stats();
                write_period(CFG_T1_PERIOD, pick_period());
                write_period(CFG_T2_PERIOD, pick_period());
            end else if ($urandom_range(5) == 0) begin
                // sender holds off until every statistic is out
                drain_stats();
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                v = next_sample(v);
                push_sample(v, i == len - 1);
            end
            sent += len;
            runs++;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed part: sender rarely idles, receiver mostly stalls ---
        // single-sample runs at the extremes, under the reset strides
        push_sample(32'h7FFF_FFFF, 1'b1);
        push_sample(32'h8000_0000, 1'b1);
        // mixed run: extremes, equal pairs, increases and decreases
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'h0000_0005, 1'b1);
        // negative odd sum: mean must round toward zero
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0000, 1'b1);

        // stride register of zero acts as 1, 511 (above the range) as the max
        drain_stats();
        write_period(CFG_T1_PERIOD, 9'd0);
        write_period(CFG_T2_PERIOD, 9'h1FF);
        push_sample(32'd4, 1'b0);
        push_sample(32'd4, 1'b0);
        push_sample(32'd9, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd2, 1'b1);

        // longer run of wide values under stride 3 and the largest stride
        drain_stats();
        write_period(CFG_T1_PERIOD, 9'd3);
        write_period(CFG_T2_PERIOD, 9'd256);
        for (int i = 0; i < 40; i++)
            push_sample($urandom, i == 39);

        // --- random part, three idling regimes ---
        random_phase(85);
        drain_stats();
        send_idle = 84;
        recv_idle = 7;
        random_phase(85);
        drain_stats();
        send_idle = 0;
        recv_idle = 0;
        random_phase(85);

        drain_stats();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
